>>> design/cia_pkg.sv
// Shared types and constants for the complex integer ALU.
package cia_pkg;

    localparam int FIELD_W       = 16;
    localparam int MODE_W        = 4;
    localparam int RES_W         = 32;
    localparam int DIV_STEP_BITS = 2;

    localparam logic [MODE_W-1:0] MODE_ADD = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 4'd3;
    localparam logic [MODE_W-1:0] MODE_EQ  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_NE  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_LT  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_GT  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LE  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_GE  = 4'd9;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [FIELD_W-1:0] a_real;
        logic signed [FIELD_W-1:0] a_imag;
        logic signed [FIELD_W-1:0] b_real;
        logic signed [FIELD_W-1:0] b_imag;
    } in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] res_real;
        logic signed [RES_W-1:0] res_imag;
        logic                    compare_true;
        logic                    divide_error;
    } out_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              cmp;
        logic              err;
        logic              re_neg;
        logic              im_neg;
    } ctrl_t;

endpackage

>>> design/cia_front.sv
// Front pipeline: operand capture, products, sums, sign/magnitude split.
module cia_front
    import cia_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  in_t                          in_data,
    output logic                         valid,
    output ctrl_t                        ctrl,
    output logic [2*OPERAND_WIDTH-1:0]   num_re,
    output logic [2*OPERAND_WIDTH-1:0]   num_im,
    output logic [2*OPERAND_WIDTH-1:0]   divisor
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;
    localparam int SW  = PW + 1;
    localparam int EXW = (W > FIELD_W) ? W : FIELD_W;

    function automatic logic signed [W-1:0] take_operand(input logic [FIELD_W-1:0] f);
        logic [EXW-1:0] ext;
        ext = EXW'(f);
        return ext[W-1:0];
    endfunction

    // stage A: operands
    logic                    valid_a_reg;
    logic [MODE_W-1:0]       mode_a_reg;
    logic signed [W-1:0]     ar_a_reg, ai_a_reg, br_a_reg, bi_a_reg;

    // stage B: products
    logic                    valid_b_reg;
    logic [MODE_W-1:0]       mode_b_reg;
    logic signed [W-1:0]     ar_b_reg, ai_b_reg, br_b_reg, bi_b_reg;
    logic signed [PW-1:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0]    sq_ar_reg, sq_ai_reg, sq_br_reg, sq_bi_reg;

    // stage C: signed sums and magnitudes
    logic                    valid_c_reg;
    logic [MODE_W-1:0]       mode_c_reg;
    logic signed [SW-1:0]    re_s_reg, im_s_reg;
    logic signed [SW-1:0]    re_s_next, im_s_next;
    logic [PW-1:0]           maga_reg, magb_reg;
    logic                    eq_reg;

    // stage D: sign/magnitude, divisor
    logic                    valid_d_reg;
    ctrl_t                   ctrl_reg, ctrl_next;
    logic [PW-1:0]           num_re_reg, num_im_reg, divisor_reg;
    logic [PW-1:0]           num_re_next, num_im_next, divisor_next;
    logic [SW-1:0]           re_abs, im_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_comb
    begin
        re_s_next = '0;
        im_s_next = '0;
        case (mode_b_reg)
            MODE_ADD:
            begin
                re_s_next = SW'(ar_b_reg) + SW'(br_b_reg);
                im_s_next = SW'(ai_b_reg) + SW'(bi_b_reg);
            end
            MODE_SUB:
            begin
                re_s_next = SW'(ar_b_reg) - SW'(br_b_reg);
                im_s_next = SW'(ai_b_reg) - SW'(bi_b_reg);
            end
            MODE_MUL:
            begin
                re_s_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                im_s_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            MODE_DIV:
            begin
                re_s_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                im_s_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default:
            begin
                re_s_next = '0;
                im_s_next = '0;
            end
        endcase
    end

    always_comb
    begin
        re_abs = re_s_reg[SW-1] ? $unsigned(-re_s_reg) : $unsigned(re_s_reg);
        im_abs = im_s_reg[SW-1] ? $unsigned(-im_s_reg) : $unsigned(im_s_reg);
        num_re_next = re_abs[PW-1:0];
        num_im_next = im_abs[PW-1:0];

        ctrl_next.mode   = mode_c_reg;
        ctrl_next.re_neg = re_s_reg[SW-1];
        ctrl_next.im_neg = im_s_reg[SW-1];
        ctrl_next.err    = (mode_c_reg == MODE_DIV) && (magb_reg == '0);
        case (mode_c_reg)
            MODE_EQ: ctrl_next.cmp = eq_reg;
            MODE_NE: ctrl_next.cmp = !eq_reg;
            MODE_LT: ctrl_next.cmp = maga_reg < magb_reg;
            MODE_GT: ctrl_next.cmp = maga_reg > magb_reg;
            MODE_LE: ctrl_next.cmp = maga_reg <= magb_reg;
            MODE_GE: ctrl_next.cmp = maga_reg >= magb_reg;
            default: ctrl_next.cmp = 1'b0;
        endcase

        // non-divide items pass the divider with a unit divisor
        divisor_next = (mode_c_reg == MODE_DIV) ? magb_reg : PW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_a_reg <= in_data.mode;
            ar_a_reg   <= take_operand(in_data.a_real);
            ai_a_reg   <= take_operand(in_data.a_imag);
            br_a_reg   <= take_operand(in_data.b_real);
            bi_a_reg   <= take_operand(in_data.b_imag);

            mode_b_reg <= mode_a_reg;
            ar_b_reg   <= ar_a_reg;
            ai_b_reg   <= ai_a_reg;
            br_b_reg   <= br_a_reg;
            bi_b_reg   <= bi_a_reg;
            p_rr_reg   <= PW'(ar_a_reg) * PW'(br_a_reg);
            p_ii_reg   <= PW'(ai_a_reg) * PW'(bi_a_reg);
            p_ri_reg   <= PW'(ar_a_reg) * PW'(bi_a_reg);
            p_ir_reg   <= PW'(ai_a_reg) * PW'(br_a_reg);
            sq_ar_reg  <= PW'(ar_a_reg) * PW'(ar_a_reg);
            sq_ai_reg  <= PW'(ai_a_reg) * PW'(ai_a_reg);
            sq_br_reg  <= PW'(br_a_reg) * PW'(br_a_reg);
            sq_bi_reg  <= PW'(bi_a_reg) * PW'(bi_a_reg);

            mode_c_reg <= mode_b_reg;
            re_s_reg   <= re_s_next;
            im_s_reg   <= im_s_next;
            maga_reg   <= $unsigned(sq_ar_reg) + $unsigned(sq_ai_reg);
            magb_reg   <= $unsigned(sq_br_reg) + $unsigned(sq_bi_reg);
            eq_reg     <= (ar_b_reg == br_b_reg) && (ai_b_reg == bi_b_reg);

            ctrl_reg    <= ctrl_next;
            num_re_reg  <= num_re_next;
            num_im_reg  <= num_im_next;
            divisor_reg <= divisor_next;
        end
    end

    assign valid   = valid_d_reg;
    assign ctrl    = ctrl_reg;
    assign num_re  = num_re_reg;
    assign num_im  = num_im_reg;
    assign divisor = divisor_reg;

endmodule

>>> design/cia_div_step.sv
// One divider stage: DIV_STEP_BITS restoring steps on both parts.
module cia_div_step
    import cia_pkg::*;
#(
    parameter int QW = 32
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          valid_in,
    input  ctrl_t         ctrl_in,
    input  logic [QW-1:0] divisor_in,
    input  logic [QW-1:0] rem_re_in,
    input  logic [QW-1:0] quo_re_in,
    input  logic [QW-1:0] rem_im_in,
    input  logic [QW-1:0] quo_im_in,
    output logic          valid_out,
    output ctrl_t         ctrl_out,
    output logic [QW-1:0] divisor_out,
    output logic [QW-1:0] rem_re_out,
    output logic [QW-1:0] quo_re_out,
    output logic [QW-1:0] rem_im_out,
    output logic [QW-1:0] quo_im_out
);

    // quo shifts the numerator out at the top and the quotient in at the bottom
    function automatic logic [2*QW-1:0] div_bits(input logic [QW-1:0] rem,
                                                 input logic [QW-1:0] quo,
                                                 input logic [QW-1:0] d);
        logic [QW:0]   trial;
        logic [QW-1:0] r;
        logic [QW-1:0] q;
        r = rem;
        q = quo;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {r, q[QW-1]};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                q     = {q[QW-2:0], 1'b1};
            end
            else
            begin
                q     = {q[QW-2:0], 1'b0};
            end
            r = trial[QW-1:0];
        end
        return {r, q};
    endfunction

    logic          valid_reg;
    ctrl_t         ctrl_reg;
    logic [QW-1:0] divisor_reg;
    logic [QW-1:0] rem_re_reg, quo_re_reg, rem_im_reg, quo_im_reg;
    logic [QW-1:0] rem_re_next, quo_re_next, rem_im_next, quo_im_next;

    always_comb
    begin
        {rem_re_next, quo_re_next} = div_bits(rem_re_in, quo_re_in, divisor_in);
        {rem_im_next, quo_im_next} = div_bits(rem_im_in, quo_im_in, divisor_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl_reg    <= ctrl_in;
            divisor_reg <= divisor_in;
            rem_re_reg  <= rem_re_next;
            quo_re_reg  <= quo_re_next;
            rem_im_reg  <= rem_im_next;
            quo_im_reg  <= quo_im_next;
        end
    end

    assign valid_out   = valid_reg;
    assign ctrl_out    = ctrl_reg;
    assign divisor_out = divisor_reg;
    assign rem_re_out  = rem_re_reg;
    assign quo_re_out  = quo_re_reg;
    assign rem_im_out  = rem_im_reg;
    assign quo_im_out  = quo_im_reg;

endmodule

>>> design/complex_integer_alu.sv
// Top level: pipelined Gaussian-integer ALU (add, sub, mul, div, compares).
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_ready    in_data  (in_t)
//  out      result     out_valid / out_ready  out_data (out_t)
//
// One request per cycle sustained while the pipeline advances, that is unless out_valid
// is held with out_ready low. The divider makes 2*OPERAND_WIDTH quotient bits, two per stage.
// The whole pipeline advances together; in_ready = !out_valid || out_ready.
// Reset clears only valid bits; no state survives between requests.
module complex_integer_alu
    import cia_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int W     = OPERAND_WIDTH;
    localparam int QW    = 2 * W;
    localparam int NSTEP = QW / DIV_STEP_BITS;
    localparam int MW    = (QW > RES_W) ? QW : RES_W + 1;

    localparam logic [MW-1:0] NEG_LIM = MW'({1'b1, {(RES_W-1){1'b0}}});
    localparam logic [MW-1:0] POS_LIM = MW'({1'b0, {(RES_W-1){1'b1}}});

    function automatic logic [RES_W-1:0] to_part(input logic neg, input logic [QW-1:0] mag);
        logic [MW-1:0]    m;
        logic [RES_W-1:0] r;
        m = MW'(mag);
        if (neg)
        begin
            if (m >= NEG_LIM)
                r = NEG_LIM[RES_W-1:0];
            else
                r = -m[RES_W-1:0];
        end
        else
        begin
            if (m > POS_LIM)
                r = POS_LIM[RES_W-1:0];
            else
                r = m[RES_W-1:0];
        end
        return r;
    endfunction

    logic          adv;
    logic          v_w   [0:NSTEP];
    ctrl_t         c_w   [0:NSTEP];
    logic [QW-1:0] d_w   [0:NSTEP];
    logic [QW-1:0] rr_w  [0:NSTEP];
    logic [QW-1:0] qr_w  [0:NSTEP];
    logic [QW-1:0] ri_w  [0:NSTEP];
    logic [QW-1:0] qi_w  [0:NSTEP];

    logic  out_valid_reg;
    out_t  out_data_reg, out_data_next;
    ctrl_t c_last;
    logic  parts_ok;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    cia_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .valid    (v_w[0]),
        .ctrl     (c_w[0]),
        .num_re   (qr_w[0]),
        .num_im   (qi_w[0]),
        .divisor  (d_w[0])
    );

    assign rr_w[0] = '0;
    assign ri_w[0] = '0;

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_div
        cia_div_step #(
            .QW (QW)
        ) u_step (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .valid_in    (v_w[g]),
            .ctrl_in     (c_w[g]),
            .divisor_in  (d_w[g]),
            .rem_re_in   (rr_w[g]),
            .quo_re_in   (qr_w[g]),
            .rem_im_in   (ri_w[g]),
            .quo_im_in   (qi_w[g]),
            .valid_out   (v_w[g+1]),
            .ctrl_out    (c_w[g+1]),
            .divisor_out (d_w[g+1]),
            .rem_re_out  (rr_w[g+1]),
            .quo_re_out  (qr_w[g+1]),
            .rem_im_out  (ri_w[g+1]),
            .quo_im_out  (qi_w[g+1])
        );
    end

    always_comb
    begin
        c_last   = c_w[NSTEP];
        parts_ok = !c_last.err && ((c_last.mode == MODE_ADD) || (c_last.mode == MODE_SUB) ||
                                   (c_last.mode == MODE_MUL) || (c_last.mode == MODE_DIV));
        out_data_next.res_real     = parts_ok ? to_part(c_last.re_neg, qr_w[NSTEP]) : '0;
        out_data_next.res_imag     = parts_ok ? to_part(c_last.im_neg, qi_w[NSTEP]) : '0;
        out_data_next.compare_true = c_last.cmp;
        out_data_next.divide_error = c_last.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_w[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/cia_checker.sv
// Port-level assertions for complex_integer_alu, with bind.
module cia_checker
    import cia_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_error |->
            out_data.res_real == '0 && out_data.res_imag == '0 && !out_data.compare_true)
        else $error("divide error with nonzero result fields");

    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.compare_true |->
            out_data.res_real == '0 && out_data.res_imag == '0)
        else $error("compare result with nonzero parts");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output is free");

endmodule

bind complex_integer_alu cia_checker u_cia_checker (.*);

>>> tb/sv/tb_complex_integer_alu.sv
// Self-checking testbench for complex_integer_alu: directed, back-to-back and random requests.
module tb_complex_integer_alu;
    import cia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 20;
    localparam int IDLE_LIMIT = 5000;
    localparam logic signed [FIELD_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [FIELD_W-1:0] S_MIN = 16'sh8000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    out_t pending_results[$];
    int requests_sent = 0;
    int results_checked = 0;
    int error_count = 0;
    int div_errors_seen = 0;
    int compares_true_seen = 0;
    int burst_left = 0;
    bit pacing_on = 1'b1;
    logic [15:0] rcv_cycle = '0;
    int idle_cycles = 0;

    complex_integer_alu uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #1 clk = ~clk;

    function automatic logic signed [RES_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[RES_W-1:0];
    endfunction

    function automatic out_t alu_result(in_t req);
        longint ar, ai, br, bi, mag_a, mag_b, re, im;
        out_t r;
        ar = longint'(req.a_real);
        ai = longint'(req.a_imag);
        br = longint'(req.b_real);
        bi = longint'(req.b_imag);
        mag_a = ar * ar + ai * ai;
        mag_b = br * br + bi * bi;
        re = 0;
        im = 0;
        r = '0;
        case (req.mode)
            MODE_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL:
            begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
            end
            MODE_DIV:
            begin
                if (mag_b == 0)
                    r.divide_error = 1'b1;
                else
                begin
                    re = (ar * br + ai * bi) / mag_b;
                    im = (ai * br - ar * bi) / mag_b;
                end
            end
            MODE_EQ: r.compare_true = (ar == br) && (ai == bi);
            MODE_NE: r.compare_true = (ar != br) || (ai != bi);
            MODE_LT: r.compare_true = mag_a < mag_b;
            MODE_GT: r.compare_true = mag_a > mag_b;
            MODE_LE: r.compare_true = mag_a <= mag_b;
            MODE_GE: r.compare_true = mag_a >= mag_b;
            default: ;
        endcase
        r.res_real = clamp32(re);
        r.res_imag = clamp32(im);
        return r;
    endfunction

    function automatic in_t make_request(logic [MODE_W-1:0] mode,
                                         logic signed [FIELD_W-1:0] ar,
                                         logic signed [FIELD_W-1:0] ai,
                                         logic signed [FIELD_W-1:0] br,
                                         logic signed [FIELD_W-1:0] bi);
        in_t req;
        req.mode = mode;
        req.a_real = ar;
        req.a_imag = ai;
        req.b_real = br;
        req.b_imag = bi;
        return req;
    endfunction

    // caller sits just after a rising edge
    task automatic send_request(in_t req);
        out_t exp_r;
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_r = alu_result(req);
        pending_results.push_back(exp_r);
        requests_sent++;
        if (exp_r.divide_error)
            div_errors_seen++;
        if (exp_r.compare_true)
            compares_true_seen++;
    endtask

    // bursts of random length separated by random gaps
    task automatic issue(in_t req);
        int gap;
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        send_request(req);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [FIELD_W-1:0] rand_part();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            1, 2: return FIELD_W'($urandom_range(0, 16) - 8);
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic in_t rand_request();
        in_t req;
        int k;
        k = $urandom_range(0, 31);
        req.mode = (k < 30) ? MODE_W'(k % 10) : MODE_W'($urandom_range(10, 15));
        req.a_real = rand_part();
        req.a_imag = rand_part();
        case ($urandom_range(0, 5))
            0:
            begin
                req.b_real = req.a_real;
                req.b_imag = req.a_imag;
            end
            1:
            begin
                req.b_real = -req.a_imag;
                req.b_imag = req.a_real;
            end
            2:
            begin
                req.b_real = req.a_real;
                req.b_imag = -req.a_imag;
            end
            default:
            begin
                req.b_real = rand_part();
                req.b_imag = rand_part();
            end
        endcase
        if (req.mode == MODE_DIV && $urandom_range(0, 5) == 0)
        begin
            req.b_real = '0;
            req.b_imag = '0;
        end
        return req;
    endfunction

    task automatic test_directed();
        issue(make_request(MODE_ADD, S_MAX, S_MAX, S_MAX, S_MAX));
        issue(make_request(MODE_ADD, S_MIN, S_MIN, S_MIN, S_MIN));
        issue(make_request(MODE_SUB, S_MIN, S_MAX, S_MAX, S_MIN));
        issue(make_request(MODE_SUB, S_MAX, S_MIN, S_MIN, S_MAX));
        // imaginary part reaches 2^31 and saturates
        issue(make_request(MODE_MUL, S_MIN, S_MIN, S_MIN, S_MIN));
        issue(make_request(MODE_MUL, S_MAX, S_MIN, S_MAX, S_MAX));
        issue(make_request(MODE_MUL, S_MIN, S_MAX, S_MIN, S_MIN));
        issue(make_request(MODE_DIV, 16'sd123, -16'sd45, 16'sd0, 16'sd0));
        issue(make_request(MODE_DIV, S_MIN, S_MIN, 16'sd0, 16'sd0));
        issue(make_request(MODE_DIV, S_MIN, S_MAX, 16'sd1, 16'sd0));
        issue(make_request(MODE_DIV, 16'sd7, -16'sd3, 16'sd2, 16'sd5));
        issue(make_request(MODE_DIV, -16'sd7, 16'sd3, 16'sd2, 16'sd5));
        issue(make_request(MODE_DIV, S_MAX, S_MAX, S_MIN, S_MIN));
        issue(make_request(MODE_DIV, S_MIN, S_MIN, -16'sd1, 16'sd0));
        issue(make_request(MODE_EQ, S_MIN, S_MAX, S_MIN, S_MAX));
        issue(make_request(MODE_EQ, 16'sd5, 16'sd6, 16'sd5, -16'sd6));
        issue(make_request(MODE_NE, S_MAX, S_MIN, S_MAX, S_MIN));
        issue(make_request(MODE_NE, 16'sd5, 16'sd6, 16'sd5, -16'sd6));
        // equal magnitudes: 3+4i against 5+0i
        issue(make_request(MODE_LT, 16'sd3, 16'sd4, 16'sd5, 16'sd0));
        issue(make_request(MODE_GT, 16'sd3, 16'sd4, 16'sd5, 16'sd0));
        issue(make_request(MODE_LE, 16'sd3, 16'sd4, 16'sd5, 16'sd0));
        issue(make_request(MODE_GE, 16'sd3, 16'sd4, 16'sd5, 16'sd0));
        issue(make_request(MODE_LT, S_MAX, S_MAX, S_MIN, S_MIN));
        for (int m = 10; m < 16; m++)
            issue(make_request(MODE_W'(m), S_MIN, S_MAX, S_MIN, S_MAX));
    endtask

    // full rate, then hold off until every result is back
    task automatic test_back_to_back();
        pacing_on = 1'b0;
        repeat (40)
            send_request(rand_request());
        wait_drained();
        pacing_on = 1'b1;
        burst_left = 0;
    endtask

    task automatic test_random_mix(int n);
        repeat (n)
            issue(rand_request());
    endtask

    always @(posedge clk)
    begin
        rcv_cycle <= rcv_cycle + 1'b1;
        case (rcv_cycle[8:7])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= (rcv_cycle[2:0] < 3'd5);
            default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    task automatic report_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
            end
            else
            begin
                out_t exp_r;
                exp_r = pending_results.pop_front();
                report_field("res_real", longint'(exp_r.res_real),
                             longint'(out_data.res_real));
                report_field("res_imag", longint'(exp_r.res_imag),
                             longint'(out_data.res_imag));
                report_field("compare_true", longint'(exp_r.compare_true),
                             longint'(out_data.compare_true));
                report_field("divide_error", longint'(exp_r.divide_error),
                             longint'(out_data.divide_error));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a handshake", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_random_mix(340);
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d requests over all modes incl. unused ones; checked %0d results.",
                 requests_sent, results_checked);
        $display("Divide-by-zero cases: %0d, true comparisons: %0d, mismatches: %0d.",
                 div_errors_seen, compares_true_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
